>>> rtl/core/tfgc_pkg.sv
// Shared types and constants for the two-finger gesture classifier.
// No dependencies; every other file of the block refers to this package.

package tfgc_pkg;

	localparam int TOUCH_BITS   = 4;
	localparam int FLOOR_BITS   = 8;
	localparam int CFG_IDX_BITS = 2;
	localparam int KIND_BITS    = 2;

	localparam logic [TOUCH_BITS-1:0] MIN_TOUCHES      = TOUCH_BITS'(2);
	localparam logic [FLOOR_BITS-1:0] SCROLL_FLOOR_RST = FLOOR_BITS'(3);
	localparam logic [FLOOR_BITS-1:0] PINCH_FLOOR_RST  = FLOOR_BITS'(3);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_SCROLL_FLOOR = 2'd0,
		CFG_PINCH_FLOOR  = 2'd1
	} cfg_reg_t;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_NONE   = 2'd0,
		KIND_SCROLL = 2'd1,
		KIND_PINCH  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_LOAD,
		ST_ROOT,
		ST_DECIDE
	} state_t;

	// Status of the serial square-root unit
	typedef struct packed {
		logic busy;
		logic done;
	} root_stat_t;

endpackage

>>> rtl/core/tfgc_ifs.sv
// Channel interfaces of the gesture classifier: touch frames, results, config writes.
// Depends on tfgc_pkg for field widths that do not vary.

interface tfgc_frame_if #(parameter int COORD_BITS = 11);
	logic                            valid;
	logic                            ready;
	logic [tfgc_pkg::TOUCH_BITS-1:0] touch_count;
	logic [COORD_BITS-1:0]           first_x;
	logic [COORD_BITS-1:0]           first_y;
	logic [COORD_BITS-1:0]           second_x;
	logic [COORD_BITS-1:0]           second_y;

	modport source (output valid, touch_count, first_x, first_y, second_x, second_y,
		input ready);
	modport sink (input valid, touch_count, first_x, first_y, second_x, second_y,
		output ready);
endinterface

interface tfgc_result_if #(parameter int COORD_BITS = 11);
	logic                           valid;
	logic                           ready;
	logic [tfgc_pkg::KIND_BITS-1:0] gesture_kind;
	logic signed [COORD_BITS:0]     scroll_dx;
	logic signed [COORD_BITS:0]     scroll_dy;
	logic signed [COORD_BITS+1:0]   pinch_delta;

	modport source (output valid, gesture_kind, scroll_dx, scroll_dy, pinch_delta,
		input ready);
	modport sink (input valid, gesture_kind, scroll_dx, scroll_dy, pinch_delta,
		output ready);
endinterface

interface tfgc_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [tfgc_pkg::CFG_IDX_BITS-1:0] index;
	logic [tfgc_pkg::FLOOR_BITS-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/tfgc_isqrt.sv
// Serial floor square root: two radicand bits enter per cycle, one root bit leaves.
// Depends on tfgc_pkg for the status struct.

module tfgc_isqrt #(
	parameter int RAD_BITS = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [RAD_BITS-1:0]     radicand,
	output logic [RAD_BITS/2-1:0]   root,
	output tfgc_pkg::root_stat_t    stat
);

	localparam int ROOT_BITS = RAD_BITS / 2;
	localparam int REM_BITS  = ROOT_BITS + 1;
	localparam int TRY_BITS  = ROOT_BITS + 3;
	localparam int CNT_BITS  = $clog2(ROOT_BITS);
	localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(ROOT_BITS - 1);

	logic [RAD_BITS-1:0]  rad_q;
	logic [REM_BITS-1:0]  rem_q;
	logic [ROOT_BITS-1:0] root_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [TRY_BITS-1:0]  cand;
	logic [TRY_BITS-1:0]  trial;
	logic [TRY_BITS-1:0]  diff;
	logic                 take;

	assign cand  = {rem_q, rad_q[RAD_BITS-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign diff  = cand - trial;
	assign take  = (cand >= trial);

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_BITS-3:0], 2'b00};
			rem_q  <= take ? diff[REM_BITS-1:0] : cand[REM_BITS-1:0];
			root_q <= {root_q[ROOT_BITS-2:0], take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q + 1'b1;
			busy_q <= (cnt_q != LAST_STEP);
			done_q <= (cnt_q == LAST_STEP);
		end else begin
			done_q <= 1'b0;
		end
	end

	assign root      = root_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("root unit did not start");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("root done held longer than one cycle");
	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && (cnt_q == LAST_STEP) && !start |=> done_q && !busy_q)
		else $error("root unit missed its final step");

endmodule

>>> rtl/core/two_finger_gesture_classifier_unit.sv
// Two-finger gesture classifier top level: frame capture, serial root, decision.
// Depends on tfgc_pkg, tfgc_ifs (channel interfaces) and tfgc_isqrt.
//
//   channel | dir | payload                                           | moves on
//   frame   | in  | touch_count, first_x, first_y, second_x, second_y | valid & ready
//   result  | out | gesture_kind, scroll_dx, scroll_dy, pinch_delta   | valid & ready
//   cfg     | in  | index, data (noise floors)                        | valid & ready
//
// A frame with two or more contacts passes through the square, load, root and decide states
// before the next transfer; the serial square root, one root bit per cycle, takes most of it.
// A frame with fewer than two contacts goes from capture straight to the decide state.
// One frame is in work at a time; a new frame is taken while a result still waits.
// A stalled result holds the decision stage; cfg is always ready.
// Reset clears tracking, previous distance and centroid, and sets both floors to 3.

module two_finger_gesture_classifier_unit #(
	parameter int COORD_BITS = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	tfgc_frame_if.sink    frame,
	tfgc_result_if.source result,
	tfgc_cfg_if.sink      cfg
);

	localparam int DIST_BITS  = COORD_BITS + 1;
	localparam int MOVE_BITS  = COORD_BITS + 1;
	localparam int DELTA_BITS = COORD_BITS + 2;
	localparam int SQ_BITS    = 2 * COORD_BITS;
	localparam int RAD_BITS   = 2 * COORD_BITS + 2;
	localparam int FLOOR_BITS = tfgc_pkg::FLOOR_BITS;

	tfgc_pkg::state_t state_q, state_d;

	// captured frame
	logic                   two_q;
	logic [COORD_BITS-1:0]  exm_q, eym_q;
	logic [COORD_BITS-1:0]  cx_q, cy_q;
	logic [SQ_BITS-1:0]     sqx_q, sqy_q;

	// tracking state
	logic                   tracking_q;
	logic [DIST_BITS-1:0]   prev_dist_q;
	logic [COORD_BITS-1:0]  prev_cx_q, prev_cy_q;
	logic [FLOOR_BITS-1:0]  scroll_floor_q, pinch_floor_q;

	// result register
	logic                   out_valid_q;
	tfgc_pkg::kind_t        out_kind_q;
	logic [MOVE_BITS-1:0]   out_dx_q, out_dy_q;
	logic [DELTA_BITS-1:0]  out_pd_q;

	logic                   in_fire;
	logic                   root_start;
	logic                   decide_fire;
	logic [RAD_BITS-1:0]    radicand;
	logic [DIST_BITS-1:0]   root_len;
	tfgc_pkg::root_stat_t   root_stat;

	logic [COORD_BITS:0]    sum_x, sum_y;
	logic [COORD_BITS-1:0]  adx, ady;
	logic [DELTA_BITS-1:0]  dd, mag_dd;
	logic [MOVE_BITS-1:0]   dx, dy, mag_dx, mag_dy, mag_max;
	logic                   scroll_ok, pinch_ok;
	tfgc_pkg::kind_t        kind;

	assign in_fire = frame.valid && frame.ready;

	assign adx = (frame.first_x >= frame.second_x) ? (frame.first_x - frame.second_x)
		: (frame.second_x - frame.first_x);
	assign ady = (frame.first_y >= frame.second_y) ? (frame.first_y - frame.second_y)
		: (frame.second_y - frame.first_y);
	assign sum_x = {1'b0, frame.first_x} + {1'b0, frame.second_x};
	assign sum_y = {1'b0, frame.first_y} + {1'b0, frame.second_y};

	always_ff @(posedge clk) begin
		if (in_fire) begin
			two_q <= (frame.touch_count >= tfgc_pkg::MIN_TOUCHES);
			exm_q <= adx;
			eym_q <= ady;
			cx_q  <= sum_x[COORD_BITS:1];
			cy_q  <= sum_y[COORD_BITS:1];
		end
		if (state_q == tfgc_pkg::ST_SQUARE) begin
			sqx_q <= SQ_BITS'(exm_q) * SQ_BITS'(exm_q);
			sqy_q <= SQ_BITS'(eym_q) * SQ_BITS'(eym_q);
		end
	end

	assign radicand = RAD_BITS'(sqx_q) + RAD_BITS'(sqy_q);

	tfgc_isqrt #(
		.RAD_BITS (RAD_BITS)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (radicand),
		.root     (root_len),
		.stat     (root_stat)
	);

	// decision against the stored frame
	assign dd = {1'b0, root_len} - {1'b0, prev_dist_q};
	assign dx = {1'b0, cx_q} - {1'b0, prev_cx_q};
	assign dy = {1'b0, cy_q} - {1'b0, prev_cy_q};
	assign mag_dd  = dd[DELTA_BITS-1] ? (~dd + 1'b1) : dd;
	assign mag_dx  = dx[MOVE_BITS-1] ? (~dx + 1'b1) : dx;
	assign mag_dy  = dy[MOVE_BITS-1] ? (~dy + 1'b1) : dy;
	assign mag_max = (mag_dx > mag_dy) ? mag_dx : mag_dy;

	assign scroll_ok = ({1'b0, mag_max} > mag_dd)
		&& (mag_max > {{(MOVE_BITS-FLOOR_BITS){1'b0}}, scroll_floor_q});
	assign pinch_ok  = (mag_dd > {{(DELTA_BITS-FLOOR_BITS){1'b0}}, pinch_floor_q});

	always_comb begin
		if (!two_q || !tracking_q) begin
			kind = tfgc_pkg::KIND_NONE;
		end else if (scroll_ok) begin
			kind = tfgc_pkg::KIND_SCROLL;
		end else if (pinch_ok) begin
			kind = tfgc_pkg::KIND_PINCH;
		end else begin
			kind = tfgc_pkg::KIND_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfgc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		frame.ready = 1'b0;
		root_start  = 1'b0;
		decide_fire = 1'b0;
		case (state_q)
			tfgc_pkg::ST_IDLE: begin
				frame.ready = 1'b1;
				if (frame.valid) begin
					state_d = (frame.touch_count >= tfgc_pkg::MIN_TOUCHES)
						? tfgc_pkg::ST_SQUARE : tfgc_pkg::ST_DECIDE;
				end
			end
			tfgc_pkg::ST_SQUARE: begin
				state_d = tfgc_pkg::ST_LOAD;
			end
			tfgc_pkg::ST_LOAD: begin
				root_start = 1'b1;
				state_d    = tfgc_pkg::ST_ROOT;
			end
			tfgc_pkg::ST_ROOT: begin
				if (root_stat.done) begin
					state_d = tfgc_pkg::ST_DECIDE;
				end
			end
			tfgc_pkg::ST_DECIDE: begin
				// hold until the result register is free
				if (!out_valid_q || result.ready) begin
					decide_fire = 1'b1;
					state_d     = tfgc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tfgc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_q  <= 1'b0;
			prev_dist_q <= '0;
			prev_cx_q   <= '0;
			prev_cy_q   <= '0;
		end else if (decide_fire) begin
			tracking_q <= two_q;
			if (two_q) begin
				prev_dist_q <= root_len;
				prev_cx_q   <= cx_q;
				prev_cy_q   <= cy_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scroll_floor_q <= tfgc_pkg::SCROLL_FLOOR_RST;
			pinch_floor_q  <= tfgc_pkg::PINCH_FLOOR_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				tfgc_pkg::CFG_SCROLL_FLOOR: scroll_floor_q <= cfg.data;
				tfgc_pkg::CFG_PINCH_FLOOR:  pinch_floor_q  <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (decide_fire) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (decide_fire) begin
			out_kind_q <= kind;
			out_dx_q   <= (kind == tfgc_pkg::KIND_SCROLL) ? dx : '0;
			out_dy_q   <= (kind == tfgc_pkg::KIND_SCROLL) ? dy : '0;
			out_pd_q   <= (kind == tfgc_pkg::KIND_PINCH) ? dd : '0;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.gesture_kind = out_kind_q;
	assign result.scroll_dx    = out_dx_q;
	assign result.scroll_dy    = out_dy_q;
	assign result.pinch_delta  = out_pd_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q != tfgc_pkg::ST_IDLE))
		else $error("frame transfer did not start work");
	a_root_running: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tfgc_pkg::ST_ROOT) |-> (root_stat.busy || root_stat.done))
		else $error("waiting on an idle root unit");
	a_short_frame_drops: assert property (@(posedge clk) disable iff (!arst_n)
		decide_fire && !two_q |=> !tracking_q)
		else $error("tracking kept after a short frame");
	a_pinch_only_delta: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_kind_q != tfgc_pkg::KIND_PINCH) |-> (out_pd_q == '0))
		else $error("pinch delta set on a non-pinch result");
	a_scroll_only_move: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_kind_q != tfgc_pkg::KIND_SCROLL)
		|-> (out_dx_q == '0) && (out_dy_q == '0))
		else $error("scroll motion set on a non-scroll result");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for two_finger_gesture_classifier_unit: random and directed touch
// frames, a built-in gesture predictor, random stalls on both channels and floor writes.
// Depends on tfgc_pkg, the tfgc channel interfaces and the RTL of the block.

module tb;
	import tfgc_pkg::*;

	localparam int CB          = 11;
	localparam int COORD_MAX   = (1 << CB) - 1;
	localparam int DIST_MASK   = (1 << (CB + 1)) - 1;
	localparam int PHASE_ITEMS = 305;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [TOUCH_BITS-1:0] cnt;
		logic [CB-1:0]         ax;
		logic [CB-1:0]         ay;
		logic [CB-1:0]         bx;
		logic [CB-1:0]         by;
	} frame_t;

	typedef struct {
		kind_t              kind;
		logic signed [CB:0] dx;
		logic signed [CB:0] dy;
		logic signed [CB+1:0] pd;
	} gesture_t;

	logic clk;
	logic arst_n;

	tfgc_frame_if #(.COORD_BITS(CB)) frame_ch();
	tfgc_result_if #(.COORD_BITS(CB)) result_ch();
	tfgc_cfg_if cfg_ch();

	two_finger_gesture_classifier_unit #(.COORD_BITS(CB)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// predictor state and register copies
	bit                  track_two;
	int                  held_len;
	int                  last_cx;
	int                  last_cy;
	logic [FLOOR_BITS-1:0] scroll_floor;
	logic [FLOOR_BITS-1:0] pinch_floor;

	frame_t   frame_backlog[$];
	gesture_t expected_gestures[$];
	frame_t   next_frame;
	frame_t   taken_frame;
	gesture_t want;

	bit frame_taken;
	int send_gap;
	int send_calm;
	int stall_left;
	int sink_calm;
	int cycle_count;
	int faults;
	int frames_in;
	int phases_run;
	int scrolls_seen;
	int pinches_seen;
	int nones_seen;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	task automatic log_fault(string msg);
		if (faults < 40)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
		faults++;
	endtask

	function automatic int magnitude(int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic int clamp_coord(int v);
		return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
	endfunction

	// Mostly short gaps, a few long ones, and now and then a stretch with none.
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(99);
		if (r < 3) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic gesture_t classify_frame(frame_t f);
		gesture_t g;
		int ex, ey, sq, root, trial, cur_len, cx, cy, dd, dx, dy, m, md;
		g.kind = KIND_NONE;
		g.dx = '0;
		g.dy = '0;
		g.pd = '0;
		if (f.cnt < MIN_TOUCHES) begin
			track_two = 1'b0;
		end else begin
			ex = int'(f.ax) - int'(f.bx);
			ey = int'(f.ay) - int'(f.by);
			sq = ex * ex + ey * ey;
			// floor root, one bit at a time from the top
			root = 0;
			for (int b = CB + 1; b >= 0; b--) begin
				trial = root | (1 << b);
				if (trial * trial <= sq)
					root = trial;
			end
			cur_len = root & DIST_MASK;
			cx = (int'(f.ax) + int'(f.bx)) >> 1;
			cy = (int'(f.ay) + int'(f.by)) >> 1;
			if (track_two) begin
				dd = cur_len - held_len;
				dx = cx - last_cx;
				dy = cy - last_cy;
				m = (magnitude(dx) > magnitude(dy)) ? magnitude(dx) : magnitude(dy);
				md = magnitude(dd);
				if (m > md && m > int'(scroll_floor)) begin
					g.kind = KIND_SCROLL;
					g.dx = (CB+1)'(dx);
					g.dy = (CB+1)'(dy);
				end else if (md > int'(pinch_floor)) begin
					g.kind = KIND_PINCH;
					g.pd = (CB+2)'(dd);
				end
			end
			track_two = 1'b1;
			held_len = cur_len;
			last_cx = cx;
			last_cy = cy;
		end
		return g;
	endfunction

	task automatic push_frame(int cnt, int ax, int ay, int bx, int by);
		frame_t f;
		f.cnt = TOUCH_BITS'(cnt);
		f.ax = CB'(ax);
		f.ay = CB'(ay);
		f.bx = CB'(bx);
		f.by = CB'(by);
		frame_backlog.push_back(f);
	endtask

	function automatic int rand_signed(int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	// Gesture strokes with random content, plus stray frames and lifted fingers.
	task automatic build_phase(int n);
		int made, r, len, mode, span, cnt, p, q;
		int ax, ay, bx, by;
		made = 0;
		while (made < n) begin
			r = $urandom_range(99);
			if (r < 12) begin
				push_frame($urandom_range(15), $urandom_range(COORD_MAX),
					$urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
					$urandom_range(COORD_MAX));
				made++;
			end else if (r < 20) begin
				push_frame($urandom_range(1), $urandom_range(COORD_MAX),
					$urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
					$urandom_range(COORD_MAX));
				made++;
			end else begin
				len = $urandom_range(2, 24);
				mode = $urandom_range(2);
				case ($urandom_range(3))
					0: span = 4;
					1: span = 12;
					2: span = 64;
					default: span = 300;
				endcase
				ax = $urandom_range(COORD_MAX);
				ay = $urandom_range(COORD_MAX);
				bx = $urandom_range(COORD_MAX);
				by = $urandom_range(COORD_MAX);
				for (int j = 0; j < len && made < n; j++) begin
					if (j > 0) begin
						case (mode)
							0: begin
								p = rand_signed(span);
								q = rand_signed(span);
								ax = clamp_coord(ax + p + rand_signed(1));
								bx = clamp_coord(bx + p + rand_signed(1));
								ay = clamp_coord(ay + q + rand_signed(1));
								by = clamp_coord(by + q + rand_signed(1));
							end
							1: begin
								p = rand_signed(span / 2 + 1);
								q = rand_signed(span / 2 + 1);
								ax = clamp_coord(ax - p);
								bx = clamp_coord(bx + p);
								ay = clamp_coord(ay - q);
								by = clamp_coord(by + q);
							end
							default: begin
								ax = clamp_coord(ax + rand_signed(span));
								ay = clamp_coord(ay + rand_signed(span));
								bx = clamp_coord(bx + rand_signed(span));
								by = clamp_coord(by + rand_signed(span));
							end
						endcase
					end
					r = $urandom_range(99);
					if (r < 4)
						cnt = $urandom_range(1);
					else if (r < 24)
						cnt = $urandom_range(3, 15);
					else
						cnt = 2;
					push_frame(cnt, ax, ay, bx, by);
					made++;
				end
			end
		end
	endtask

	// Hold until every frame is sent and every result is back, then let the core settle.
	// Sample at the rising edge, where the driver's last update is already visible.
	task automatic wait_drained();
		while (frame_backlog.size() != 0 || expected_gestures.size() != 0 || frame_ch.valid)
			@(posedge clk);
		repeat (CB + 8) @(negedge clk);
	endtask

	task automatic write_floor(cfg_reg_t idx, logic [FLOOR_BITS-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		if (idx == CFG_SCROLL_FLOOR)
			scroll_floor = val;
		else
			pinch_floor = val;
	endtask

	task automatic set_floors(int s, int p);
		wait_drained();
		write_floor(CFG_SCROLL_FLOOR, FLOOR_BITS'(s));
		write_floor(CFG_PINCH_FLOOR, FLOOR_BITS'(p));
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// frame driver
	always @(negedge clk) begin
		if (!frame_ch.valid || frame_taken) begin
			frame_taken = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				frame_ch.valid <= 1'b0;
			end else if (frame_backlog.size() != 0) begin
				next_frame = frame_backlog.pop_front();
				frame_ch.valid <= 1'b1;
				frame_ch.touch_count <= next_frame.cnt;
				frame_ch.first_x <= next_frame.ax;
				frame_ch.first_y <= next_frame.ay;
				frame_ch.second_x <= next_frame.bx;
				frame_ch.second_y <= next_frame.by;
				send_gap = pick_gap(send_calm);
			end else begin
				frame_ch.valid <= 1'b0;
			end
		end
	end

	// result backpressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
			stall_left = pick_gap(sink_calm);
		end
	end

	// monitor: predict on frame transfer, check on result transfer
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_gestures.size());
			$display("TB_ERROR");
			$finish;
		end else if (arst_n) begin
			if (frame_ch.valid && frame_ch.ready) begin
				taken_frame.cnt = frame_ch.touch_count;
				taken_frame.ax = frame_ch.first_x;
				taken_frame.ay = frame_ch.first_y;
				taken_frame.bx = frame_ch.second_x;
				taken_frame.by = frame_ch.second_y;
				expected_gestures.push_back(classify_frame(taken_frame));
				frame_taken = 1'b1;
				frames_in++;
			end
			if (result_ch.valid && result_ch.ready) begin
				if (expected_gestures.size() == 0) begin
					log_fault("result transfer with no frame outstanding");
				end else begin
					want = expected_gestures.pop_front();
					case (want.kind)
						KIND_SCROLL: scrolls_seen++;
						KIND_PINCH:  pinches_seen++;
						default:     nones_seen++;
					endcase
					if (result_ch.gesture_kind !== want.kind)
						log_fault($sformatf("gesture_kind %0d, want %0d",
							result_ch.gesture_kind, want.kind));
					if (result_ch.scroll_dx !== want.dx)
						log_fault($sformatf("scroll_dx %0d, want %0d",
							result_ch.scroll_dx, want.dx));
					if (result_ch.scroll_dy !== want.dy)
						log_fault($sformatf("scroll_dy %0d, want %0d",
							result_ch.scroll_dy, want.dy));
					if (result_ch.pinch_delta !== want.pd)
						log_fault($sformatf("pinch_delta %0d, want %0d",
							result_ch.pinch_delta, want.pd));
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		frame_ch.valid = 1'b0;
		frame_ch.touch_count = '0;
		frame_ch.first_x = '0;
		frame_ch.first_y = '0;
		frame_ch.second_x = '0;
		frame_ch.second_y = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_SCROLL_FLOOR;
		cfg_ch.data = '0;
		track_two = 1'b0;
		held_len = 0;
		last_cx = 0;
		last_cy = 0;
		scroll_floor = SCROLL_FLOOR_RST;
		pinch_floor = PINCH_FLOOR_RST;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed frames at the reset floors
		push_frame(0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		push_frame(2, 0, 0, COORD_MAX, COORD_MAX);          // first frame records only
		push_frame(2, COORD_MAX, COORD_MAX, 0, 0);          // swapped points, no change
		push_frame(15, 0, COORD_MAX, COORD_MAX, 0);         // many contacts
		push_frame(2, 1000, 1000, 1000, 1000);              // full pinch in
		push_frame(2, 0, 0, COORD_MAX, COORD_MAX);          // full pinch out
		push_frame(1, 5, 5, 9, 9);                          // lift drops tracking
		push_frame(2, 0, 0, 0, 0);
		push_frame(2, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX); // equal components
		push_frame(2, 0, 0, 0, 0);
		push_frame(3, COORD_MAX, 0, COORD_MAX, 0);
		push_frame(2, 0, COORD_MAX, 0, COORD_MAX);
		push_frame(2, 100, 100, 110, 100);
		push_frame(2, 104, 100, 114, 100);                  // just above scroll floor
		push_frame(2, 107, 100, 117, 100);                  // at scroll floor
		push_frame(2, 107, 100, 121, 100);
		push_frame(2, 107, 100, 125, 100);                  // pinch above floor
		push_frame(2, 107, 100, 128, 100);                  // pinch at floor
		push_frame(2, 107, 100, 136, 100);
		push_frame(2, 109, 100, 142, 100);                  // motion equals distance change
		push_frame(0, 0, 0, 0, 0);

		set_floors(0, 0);
		build_phase(PHASE_ITEMS);
		set_floors(255, 255);
		build_phase(PHASE_ITEMS);
		set_floors(255, 0);
		build_phase(PHASE_ITEMS);
		set_floors(0, 255);
		build_phase(PHASE_ITEMS);
		set_floors($urandom_range(1, 254), $urandom_range(1, 254));
		build_phase(PHASE_ITEMS);
		set_floors(3, 3);
		build_phase(PHASE_ITEMS);
		phases_run = 7;
		wait_drained();

		$display("%0d frames over %0d floor settings, stalls on both channels", frames_in,
			phases_run);
		$display("results: %0d scroll, %0d pinch, %0d none; %0d mismatches", scrolls_seen,
			pinches_seen, nones_seen, faults);
		if (faults == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
